// ----- rtl/multibuffer_slot_rotation_defines.svh -----
// ----------------------------------------------------------------------------
// multibuffer slot rotation assertion macros
// shared assertion forms for the slot rotation block
// ----------------------------------------------------------------------------
`ifndef MULTIBUFFER_SLOT_ROTATION_DEFINES_SVH
`define MULTIBUFFER_SLOT_ROTATION_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define MSR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define MSR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/msr_pkg.sv -----
// ----------------------------------------------------------------------------
// msr_pkg
// types and codes shared by the slot rotation block
// ----------------------------------------------------------------------------
package msr_pkg;

    localparam int SLOT_COUNT_DEF = 4;

    localparam logic [1:0] CMD_UPDATE  = 2'd0;
    localparam logic [1:0] CMD_ENSURE  = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;
    localparam logic [1:0] CMD_SPARE   = 2'd3;

    localparam logic [2:0] ACT_CREATED   = 3'd0;
    localparam logic [2:0] ACT_UPDATED   = 3'd1;
    localparam logic [2:0] ACT_NO_CHANGE = 3'd2;
    localparam logic [2:0] ACT_RELEASED  = 3'd3;
    localparam logic [2:0] ACT_ALREADY   = 3'd4;
    localparam logic [2:0] ACT_NO_FREE   = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN1,
        ST_SCAN2,
        ST_DECIDE,
        ST_WRITE,
        ST_SCAN3,
        ST_DONE
    } state_t;

    // one slot as carried between cells
    typedef struct packed {
        logic        valid;
        logic [31:0] frame;
        logic [31:0] rstart;
        logic [31:0] rend;
    } slot_t;

    // control from the sequencer to every cell
    typedef struct packed {
        logic        shift;
        logic        clear_all;
        logic        load;
        slot_t       load_data;
    } cell_ctrl_t;

endpackage

// ----- rtl/msr_cell.sv -----
// ----------------------------------------------------------------------------
// msr_cell
// one slot of the rotating ring; clears, loads at the head, or shifts its slot to the neighbor when asked
// ----------------------------------------------------------------------------
module msr_cell
    import msr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       is_head,
    input  slot_t      prev,
    output slot_t      slot
);

    slot_t slot_reg;
    slot_t slot_next;

    always_comb
    begin
        slot_next = slot_reg;
        if (ctrl.clear_all)
        begin
            slot_next = '{valid: 1'b0, frame: '1, rstart: '1, rend: '1};
        end
        else if (ctrl.load && is_head)
        begin
            slot_next = ctrl.load_data;
        end
        else if (ctrl.shift)
        begin
            slot_next = prev;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '{valid: 1'b0, frame: '1, rstart: '1, rend: '1};
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

    assign slot = slot_reg;

endmodule

// ----- rtl/multibuffer_slot_rotation.sv -----
// ----------------------------------------------------------------------------
// multibuffer_slot_rotation
// a command runs the scan, widen, write and newest passes of the slot ring past the
// head cell; the newest pass takes an extra full turn when a slot other than 0 is written
// busy drops with done, and a new command is taken only while idle; no stall input
// reset clears all slots to invalid with all-ones stamps and ranges
// ----------------------------------------------------------------------------
module multibuffer_slot_rotation
    import msr_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [31:0] frame_number,
    input  logic [30:0] touch_start,
    input  logic [30:0] touch_end,
    input  logic [30:0] buffer_size,
    output logic        done,
    output logic [2:0]  action,
    output logic [3:0]  slot_index,
    output logic [30:0] range_start,
    output logic [30:0] range_end,
    output logic [3:0]  latest_slot,
    output logic        latest_valid
);

    localparam int IW = $clog2(SLOT_COUNT);

    // ring: cell i takes from cell i+1, head is cell 0; after SLOT_COUNT shifts
    // the ring is back in place. the counter tracks which slot sits in cell 0
    state_t      state_reg, state_next;
    logic [IW:0] cnt_reg, cnt_next;
    logic [1:0]  cmd_reg, cmd_next;
    logic [31:0] frm_reg, frm_next;
    logic [30:0] ds_reg, ds_next, de_reg, de_next, sz_reg, sz_next;
    logic        seen_reg, seen_next;
    logic        old_ok_reg, old_ok_next;
    logic [IW-1:0] old_idx_reg, old_idx_next;
    logic [31:0] old_frm_reg, old_frm_next;
    logic        free_ok_reg, free_ok_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic [31:0] lo_reg, lo_next, hi_reg, hi_next;
    logic        new_ok_reg, new_ok_next;
    logic [IW-1:0] new_idx_reg, new_idx_next;
    logic [31:0] new_frm_reg, new_frm_next;
    logic [IW-1:0] wr_idx_reg, wr_idx_next;
    logic        wr_en_reg, wr_en_next;
    logic [2:0]  act_reg, act_next;
    logic [30:0] rs_reg, rs_next, re_reg, re_next;
    logic        done_reg, done_next;

    cell_ctrl_t ctrl;
    slot_t      cells [SLOT_COUNT];
    slot_t      head;
    logic [IW-1:0] pos;

    assign head = cells[0];
    assign pos  = cnt_reg[IW-1:0];

    for (genvar g = 0; g < SLOT_COUNT; g++)
    begin : g_cell
        msr_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .is_head (g == 0),
            .prev    (cells[(g + 1) % SLOT_COUNT]),
            .slot    (cells[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;   frm_reg <= frm_next;
        ds_reg <= ds_next;     de_reg <= de_next;     sz_reg <= sz_next;
        seen_reg <= seen_next;
        old_ok_reg <= old_ok_next; old_idx_reg <= old_idx_next;
        old_frm_reg <= old_frm_next;
        free_ok_reg <= free_ok_next; free_idx_reg <= free_idx_next;
        lo_reg <= lo_next;     hi_reg <= hi_next;
        new_ok_reg <= new_ok_next; new_idx_reg <= new_idx_next;
        new_frm_reg <= new_frm_next;
        wr_idx_reg <= wr_idx_next; wr_en_reg <= wr_en_next;
        act_reg <= act_next;   rs_reg <= rs_next;     re_reg <= re_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        cmd_next = cmd_reg; frm_next = frm_reg;
        ds_next = ds_reg; de_next = de_reg; sz_next = sz_reg;
        seen_next = seen_reg;
        old_ok_next = old_ok_reg; old_idx_next = old_idx_reg;
        old_frm_next = old_frm_reg;
        free_ok_next = free_ok_reg; free_idx_next = free_idx_reg;
        lo_next = lo_reg; hi_next = hi_reg;
        new_ok_next = new_ok_reg; new_idx_next = new_idx_reg;
        new_frm_next = new_frm_reg;
        wr_idx_next = wr_idx_reg; wr_en_next = wr_en_reg;
        act_next = act_reg; rs_next = rs_reg; re_next = re_reg;
        done_next = 1'b0;
        ctrl = '{shift: 1'b0, clear_all: 1'b0, load: 1'b0, load_data: '0};
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next = command; frm_next = frame_number;
                    ds_next = touch_start; de_next = touch_end;
                    sz_next = buffer_size;
                    seen_next = 1'b0; old_ok_next = 1'b0; free_ok_next = 1'b0;
                    cnt_next = '0;
                    state_next = ST_SCAN1;
                end
            end
            ST_SCAN1:
            begin
                // stamp match, oldest valid, first free
                ctrl.shift = 1'b1;
                if (head.frame == frm_reg)
                    seen_next = 1'b1;
                if (head.valid && (!old_ok_reg || head.frame < old_frm_reg))
                begin
                    old_ok_next = 1'b1; old_idx_next = pos; old_frm_next = head.frame;
                end
                if (!head.valid && !free_ok_reg)
                begin
                    free_ok_next = 1'b1; free_idx_next = pos;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (IW+1)'(SLOT_COUNT - 1))
                begin
                    cnt_next = '0;
                    lo_next = {1'b0, ds_reg}; hi_next = {1'b0, de_reg};
                    state_next = ST_SCAN2;
                end
            end
            ST_SCAN2:
            begin
                // widen dirty range by every slot newer than the oldest
                ctrl.shift = 1'b1;
                if (head.valid && head.frame > old_frm_reg)
                begin
                    if (head.rstart < lo_next) lo_next = head.rstart;
                    if (head.rend > hi_next) hi_next = head.rend;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (IW+1)'(SLOT_COUNT - 1))
                begin
                    cnt_next = '0;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                act_next = ACT_NO_CHANGE; rs_next = '0; re_next = '0;
                wr_en_next = 1'b0; wr_idx_next = '0;
                case (cmd_reg)
                    CMD_UPDATE:
                    begin
                        if (seen_reg)
                            act_next = ACT_ALREADY;
                        else if (!old_ok_reg)
                        begin
                            act_next = ACT_CREATED; wr_en_next = 1'b1;
                            re_next = sz_reg;
                        end
                        else if ((frm_reg - old_frm_reg) < 32'(SLOT_COUNT))
                        begin
                            if (!free_ok_reg)
                                act_next = ACT_NO_FREE;
                            else
                            begin
                                act_next = ACT_CREATED; wr_en_next = 1'b1;
                                wr_idx_next = free_idx_reg; re_next = sz_reg;
                            end
                        end
                        else
                        begin
                            act_next = ACT_UPDATED; wr_en_next = 1'b1;
                            wr_idx_next = old_idx_reg;
                            rs_next = lo_reg[30:0]; re_next = hi_reg[30:0];
                        end
                    end
                    CMD_ENSURE:
                    begin
                        if (!free_ok_reg || free_idx_reg != '0)
                            act_next = ACT_NO_CHANGE;
                        else
                        begin
                            act_next = ACT_CREATED; wr_en_next = 1'b1;
                            re_next = sz_reg;
                        end
                    end
                    CMD_RELEASE:
                    begin
                        act_next = ACT_RELEASED;
                        ctrl.clear_all = 1'b1;
                    end
                    default:
                    begin
                        act_next = ACT_NO_CHANGE;
                    end
                endcase
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                // rotate until the target slot is at the head, then load it
                if (!wr_en_reg || pos == wr_idx_reg)
                begin
                    if (wr_en_reg)
                    begin
                        ctrl.load = 1'b1;
                        ctrl.load_data = '{valid: 1'b1, frame: frm_reg,
                                           rstart: {1'b0, rs_reg}, rend: {1'b0, re_reg}};
                    end
                    state_next = ST_SCAN3;
                    new_ok_next = 1'b0;
                end
                else
                begin
                    ctrl.shift = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SCAN3:
            begin
                // newest slot; a ring left rotated takes one more full turn
                ctrl.shift = 1'b1;
                if (head.valid && (!new_ok_reg || head.frame > new_frm_reg
                    || (head.frame == new_frm_reg && pos < new_idx_reg)))
                begin
                    new_ok_next = 1'b1; new_idx_next = pos; new_frm_next = head.frame;
                end
                cnt_next = cnt_reg + 1'b1;
                if (pos == IW'(SLOT_COUNT - 1))
                begin
                    if (cnt_reg[IW] || !wr_en_reg || wr_idx_reg == '0)
                    begin
                        cnt_next = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cnt_next = {1'b1, {IW{1'b0}}};
                    end
                end
            end
            ST_DONE:
            begin
                done_next = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign action       = act_reg;
    assign slot_index   = 4'(wr_idx_reg) & {4{wr_en_reg}};
    assign range_start  = rs_reg;
    assign range_end    = re_reg;
    assign latest_slot  = new_ok_reg ? 4'(new_idx_reg) : 4'd0;
    assign latest_valid = new_ok_reg;

`include "multibuffer_slot_rotation_defines.svh"

    `MSR_ASSERT_IMP(a_done_one_cycle, done, !$past(done))
    `MSR_ASSERT_NEXT(a_start_busy, start && !busy, busy)
    `MSR_ASSERT_IMP(a_idle_not_done, done, !busy)
    `MSR_ASSERT_IMP(a_updated_has_slot, done && action == ACT_UPDATED, latest_valid)

endmodule

// ----- verif/multibuffer_slot_rotation_test.sv -----
// ----------------------------------------------------------------------------
// multibuffer_slot_rotation_test
// drives update, ensure, release and spare commands into the slot rotation block,
// keeps its own model of the slot table and checks every result beat
// ----------------------------------------------------------------------------
module multibuffer_slot_rotation_test
    import msr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = SLOT_COUNT_DEF;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] frame_number;
        logic [30:0] touch_start;
        logic [30:0] touch_end;
        logic [30:0] buffer_size;
    } cmd_beat_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [3:0]  slot_index;
        logic [30:0] range_start;
        logic [30:0] range_end;
        logic [3:0]  latest_slot;
        logic        latest_valid;
    } res_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  command = '0;
    logic [31:0] frame_number = '0;
    logic [30:0] touch_start = '0;
    logic [30:0] touch_end = '0;
    logic [30:0] buffer_size = '0;
    logic        busy;
    logic        done;
    logic [2:0]  action;
    logic [3:0]  slot_index;
    logic [30:0] range_start;
    logic [30:0] range_end;
    logic [3:0]  latest_slot;
    logic        latest_valid;

    multibuffer_slot_rotation uut (.*);

    always #1 clk = ~clk;

    cmd_beat_t   pending_cmds[$];
    res_beat_t   expected_results[$];
    logic        tbl_valid[NSLOT];
    logic [31:0] tbl_frame[NSLOT];
    logic [31:0] tbl_lo[NSLOT];
    logic [31:0] tbl_hi[NSLOT];
    int          mismatches = 0;
    int          sent_count = 0;
    logic [31:0] cur_frame = 32'd100;

    function automatic int pick_slot(bit newest);
        int best;
        best = -1;
        for (int i = 0; i < NSLOT; i++)
            if (tbl_valid[i] && (best < 0 ||
                (newest ? tbl_frame[i] > tbl_frame[best]
                        : tbl_frame[i] < tbl_frame[best])))
                best = i;
        return best;
    endfunction

    function automatic void fill_slot(int i, logic [31:0] f, logic [31:0] lo,
                                      logic [31:0] hi);
        tbl_valid[i] = 1'b1;
        tbl_frame[i] = f;
        tbl_lo[i] = lo;
        tbl_hi[i] = hi;
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < NSLOT; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_frame[i] = '1;
            tbl_lo[i] = '1;
            tbl_hi[i] = '1;
        end
    endfunction

    function automatic res_beat_t rotate_slots(cmd_beat_t c);
        res_beat_t r;
        bit seen;
        int old;
        int fr;
        int nw;
        logic [31:0] lo;
        logic [31:0] hi;
        r = '0;
        r.action = ACT_NO_CHANGE;
        if (c.command == CMD_UPDATE)
        begin
            seen = 0;
            for (int i = 0; i < NSLOT; i++)
                if (tbl_frame[i] == c.frame_number)
                    seen = 1;
            old = pick_slot(0);
            if (seen)
                r.action = ACT_ALREADY;
            else if (old < 0)
            begin
                fill_slot(0, c.frame_number, 0, {1'b0, c.buffer_size});
                r.action = ACT_CREATED;
                r.range_end = c.buffer_size;
            end
            else if (32'(c.frame_number - tbl_frame[old]) < NSLOT)
            begin
                fr = -1;
                for (int i = NSLOT - 1; i >= 0; i--)
                    if (!tbl_valid[i])
                        fr = i;
                if (fr < 0)
                    r.action = ACT_NO_FREE;
                else
                begin
                    fill_slot(fr, c.frame_number, 0, {1'b0, c.buffer_size});
                    r.action = ACT_CREATED;
                    r.slot_index = 4'(fr);
                    r.range_end = c.buffer_size;
                end
            end
            else
            begin
                lo = {1'b0, c.touch_start};
                hi = {1'b0, c.touch_end};
                for (int i = 0; i < NSLOT; i++)
                    if (tbl_valid[i] && tbl_frame[i] > tbl_frame[old])
                    begin
                        if (tbl_lo[i] < lo) lo = tbl_lo[i];
                        if (tbl_hi[i] > hi) hi = tbl_hi[i];
                    end
                lo[31] = 1'b0;
                hi[31] = 1'b0;
                fill_slot(old, c.frame_number, lo, hi);
                r.action = ACT_UPDATED;
                r.slot_index = 4'(old);
                r.range_start = lo[30:0];
                r.range_end = hi[30:0];
            end
        end
        else if (c.command == CMD_ENSURE)
        begin
            if (!tbl_valid[0])
            begin
                fill_slot(0, c.frame_number, 0, {1'b0, c.buffer_size});
                r.action = ACT_CREATED;
                r.range_end = c.buffer_size;
            end
        end
        else if (c.command == CMD_RELEASE)
        begin
            clear_table();
            r.action = ACT_RELEASED;
        end
        nw = pick_slot(1);
        r.latest_slot = (nw < 0) ? 4'd0 : 4'(nw);
        r.latest_valid = (nw >= 0);
        return r;
    endfunction

    function automatic void add_cmd(logic [1:0] op, logic [31:0] f, logic [30:0] ds,
                                    logic [30:0] de, logic [30:0] sz);
        cmd_beat_t c;
        c.command = op;
        c.frame_number = f;
        c.touch_start = ds;
        c.touch_end = de;
        c.buffer_size = sz;
        pending_cmds.push_back(c);
    endfunction

    function automatic logic [30:0] rand31();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 31'($urandom_range(0, 255));
            default: return 31'($urandom);
        endcase
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_results.push_back(rotate_slots({command, frame_number,
                                                         touch_start, touch_end,
                                                         buffer_size}));
            end
            if ((!start || !busy) && pending_cmds.size() > 0
                && ((sent_count >= 300 && sent_count < 450)
                    || $urandom_range(0, 99) >= 21))
            begin
                {command, frame_number, touch_start, touch_end, buffer_size}
                    <= pending_cmds.pop_front();
                start <= 1'b1;
                sent_count++;
            end
            else if (!start || !busy)
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        res_beat_t got;
        res_beat_t exp_r;
        if (rst_n && done)
        begin
            got = {action, slot_index, range_start, range_end, latest_slot, latest_valid};
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %h", got);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (got !== exp_r)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected act %0d idx %0d rng %h..%h ",
                                  "new %0d/%0d, got act %0d idx %0d rng %h..%h new %0d/%0d"},
                            exp_r.action, exp_r.slot_index, exp_r.range_start,
                            exp_r.range_end, exp_r.latest_slot, exp_r.latest_valid,
                            got.action, got.slot_index, got.range_start,
                            got.range_end, got.latest_slot, got.latest_valid);
                end
            end
        end
    end

    initial
    begin
        #400000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        int op;
        clear_table();
        // directed
        add_cmd(CMD_ENSURE, 32'd5, 0, 0, '1);
        add_cmd(CMD_ENSURE, 32'd6, 0, 0, 0);
        add_cmd(CMD_UPDATE, 32'd5, 1, 2, 3);
        add_cmd(CMD_UPDATE, 32'd6, 0, 0, 31'd100);
        add_cmd(CMD_UPDATE, 32'd7, 0, 0, 31'd200);
        add_cmd(CMD_UPDATE, 32'd8, 0, 0, 31'd300);
        add_cmd(CMD_UPDATE, 32'd9, 5, 10, 0);
        add_cmd(CMD_UPDATE, 32'd9, 5, 10, 0);
        add_cmd(CMD_UPDATE, 32'd10, '1, 0, 0);
        add_cmd(CMD_UPDATE, 32'd11, 0, '1, 0);
        add_cmd(CMD_SPARE, 32'd12, 0, 0, 0);
        add_cmd(CMD_RELEASE, 32'd12, 0, 0, 0);
        add_cmd(CMD_UPDATE, '1, 1, 1, 1);
        add_cmd(CMD_UPDATE, 32'hFFFF_FFFE, 0, 0, '1);
        add_cmd(CMD_UPDATE, '1, 3, 4, 5);
        add_cmd(CMD_UPDATE, 32'd0, 0, 0, 6);
        add_cmd(CMD_UPDATE, 32'd1, 0, 0, 7);
        add_cmd(CMD_UPDATE, 32'd2, 0, 0, 8);
        add_cmd(CMD_UPDATE, 32'd3, 9, 9, 9);
        add_cmd(CMD_UPDATE, 32'd4, 9, 9, 9);
        add_cmd(CMD_RELEASE, 0, '1, '1, '1);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        // random: mostly advancing frames with occasional jumps and noise
        for (int n = 0; n < 950; n++)
        begin
            op = $urandom_range(0, 99);
            if (op < 3)
                add_cmd(CMD_RELEASE, $urandom, rand31(), rand31(), rand31());
            else if (op < 8)
                add_cmd(CMD_ENSURE, $urandom, rand31(), rand31(), rand31());
            else if (op < 10)
                add_cmd(CMD_SPARE, $urandom, rand31(), rand31(), rand31());
            else
            begin
                case ($urandom_range(0, 9))
                    0: cur_frame = $urandom;
                    1: cur_frame = cur_frame;
                    2: cur_frame = cur_frame + $urandom_range(2, 6);
                    default: cur_frame = cur_frame + 1;
                endcase
                add_cmd(CMD_UPDATE, cur_frame, rand31(), rand31(), rand31());
            end
        end
        wait (pending_cmds.size() == 0);
        wait (expected_results.size() == 0 && !start);
        repeat (40) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
